// ===== hw/rtl/wtc_pkg.sv =====
// Shared types, character codes and sizes for the word tokenizer.
`timescale 1ns / 1ps

package wtc_pkg;

    // Counter widths
    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Tab stops every TAB_WIDTH columns (power of two)
    localparam int TAB_WIDTH = 8;
    localparam int TAB_SHIFT = $clog2(TAB_WIDTH);

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // Result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_WEND   = 2'd1;
    localparam logic [1:0] KIND_UNTERM = 2'd2;
    localparam logic [1:0] KIND_IEND   = 2'd3;

    // One result entry
    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             word_char;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
        logic                   last_of_run;
    } result_t;

    // Results of one request: up to two entries, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } step_out_t;

endpackage

// ===== hw/rtl/wtc_step.sv =====
// Tokenizer state and per-byte result logic.
`timescale 1ns / 1ps

module wtc_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    output wtc_pkg::step_out_t step_out
);
    import wtc_pkg::*;

    typedef enum logic [1:0] {
        MODE_GAP,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_CLOSED
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic                   quote_reg, quote_next;
    logic                   comment_reg, comment_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;

    function automatic result_t mk_result(
        input logic [1:0]             k,
        input logic [7:0]             ch,
        input logic [LINE_BITS-1:0]   ln,
        input logic [COLUMN_BITS-1:0] cl
    );
        result_t r;
        r.kind          = k;
        r.word_char     = (k == KIND_CHAR) ? ch : 8'h00;
        r.line_number   = ln;
        r.column_number = cl;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Per-byte decode
    always_comb
    begin
        logic                   is_end;
        logic                   drop;
        logic [7:0]             c;
        logic                   is_space;
        logic                   has_a, has_b;
        result_t                res_a, res_b;
        mode_t                  eff;
        logic [COLUMN_BITS-1:0] col_m1;
        logic [COLUMN_BITS:0]   col_ext, col_sum;

        is_end       = end_of_input || (in_byte == CH_NUL);
        mode_next    = mode_reg;
        quote_next   = quote_reg;
        comment_next = comment_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        has_a        = 1'b0;
        has_b        = 1'b0;
        res_a        = '0;
        res_b        = '0;
        eff          = mode_reg;
        drop         = 1'b0;

        // Case folding outside quotes
        c = in_byte;
        if (!quote_reg && in_byte >= CH_LOWER_A && in_byte <= CH_LOWER_Z)
        begin
            c = in_byte - CASE_DIFF;
        end
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);

        // Column after this byte
        col_m1  = col_reg - 1'b1;
        col_ext = {1'b0, col_m1};
        if (c == CH_TAB)
        begin
            col_sum = (((col_ext >> TAB_SHIFT) + 1'b1) << TAB_SHIFT) + 1'b1;
        end
        else
        begin
            col_sum = {1'b0, col_reg} + 1'b1;
        end

        if (is_end)
        begin
            // Close any open word, then report end of input; state returns to reset
            has_a = (mode_reg != MODE_GAP);
            res_a = mk_result((mode_reg == MODE_QUOTED) ? KIND_UNTERM : KIND_WEND,
                              8'h00, line_reg, col_reg);
            has_b = 1'b1;
            res_b = mk_result(KIND_IEND, 8'h00, line_reg, col_reg);
            mode_next    = MODE_GAP;
            quote_next   = 1'b0;
            comment_next = 1'b0;
            line_next    = LINE_BITS'(1);
            col_next     = COLUMN_BITS'(1);
        end
        else
        begin
            // Dropped bytes: CR, comment text, comment start
            if (comment_reg)
            begin
                drop = (in_byte != CH_NL);
                if (!drop)
                begin
                    comment_next = 1'b0;
                end
            end
            else if (in_byte == CH_CR)
            begin
                drop = 1'b1;
            end
            else if (in_byte == CH_SEMI && !quote_reg)
            begin
                drop         = 1'b1;
                comment_next = 1'b1;
            end

            if (!drop)
            begin
                if (mode_reg == MODE_CLOSED && c == CH_QUOTE)
                begin
                    // Doubled quote: continue the quoted word, nothing emitted
                    mode_next = MODE_QUOTED;
                end
                else
                begin
                    if (mode_reg == MODE_CLOSED)
                    begin
                        has_a = 1'b1;
                        res_a = mk_result(KIND_WEND, 8'h00, line_reg, col_reg);
                        eff   = MODE_GAP;
                        mode_next = MODE_GAP;
                    end
                    unique case (eff) inside
                        MODE_GAP:
                        begin
                            if (!is_space)
                            begin
                                has_b     = 1'b1;
                                res_b     = mk_result(KIND_CHAR, c, line_reg, col_reg);
                                mode_next = (c == CH_QUOTE) ? MODE_QUOTED : MODE_PLAIN;
                            end
                        end
                        MODE_PLAIN:
                        begin
                            has_b = 1'b1;
                            if (is_space)
                            begin
                                res_b     = mk_result(KIND_WEND, 8'h00, line_reg, col_reg);
                                mode_next = MODE_GAP;
                            end
                            else
                            begin
                                res_b = mk_result(KIND_CHAR, c, line_reg, col_reg);
                            end
                        end
                        MODE_QUOTED, MODE_CLOSED:
                        begin
                            has_b = 1'b1;
                            if (c == CH_NL)
                            begin
                                res_b     = mk_result(KIND_UNTERM, 8'h00, line_reg, col_reg);
                                mode_next = MODE_GAP;
                            end
                            else
                            begin
                                res_b = mk_result(KIND_CHAR, c, line_reg, col_reg);
                                if (c == CH_QUOTE)
                                begin
                                    mode_next = MODE_CLOSED;
                                end
                            end
                        end
                        default:
                        begin
                            has_b = 1'b0;
                        end
                    endcase
                end

                // Quote flag, line and column follow every delivered byte
                if (c == CH_QUOTE)
                begin
                    quote_next = ~quote_reg;
                end
                if (c == CH_NL)
                begin
                    if (line_reg != {LINE_BITS{1'b1}})
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    col_next = COLUMN_BITS'(1);
                end
                else if (col_sum > {1'b0, {COLUMN_BITS{1'b1}}})
                begin
                    col_next = {COLUMN_BITS{1'b1}};
                end
                else
                begin
                    col_next = col_sum[COLUMN_BITS-1:0];
                end
            end
        end

        // Pack results in order, mark the last
        step_out = '0;
        if (has_a)
        begin
            step_out.slot0 = res_a;
            step_out.slot1 = res_b;
            step_out.count = has_b ? 2'd2 : 2'd1;
            if (has_b)
            begin
                step_out.slot1.last_of_run = 1'b1;
            end
            else
            begin
                step_out.slot0.last_of_run = 1'b1;
            end
        end
        else if (has_b)
        begin
            step_out.slot0             = res_b;
            step_out.slot0.last_of_run = 1'b1;
            step_out.count             = 2'd1;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_GAP;
            quote_reg   <= 1'b0;
            comment_reg <= 1'b0;
            line_reg    <= LINE_BITS'(1);
            col_reg     <= COLUMN_BITS'(1);
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            quote_reg   <= quote_next;
            comment_reg <= comment_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
        end
    end

endmodule

// ===== hw/rtl/wtc_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one unless rd_stall holds.
`timescale 1ns / 1ps

module wtc_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  wtc_pkg::step_out_t              wr_data,
    input  logic                            rd_stall,
    output logic                            rd_valid,
    output wtc_pkg::result_t                rd_data,
    output logic [wtc_pkg::LEVEL_BITS-1:0]  level
);
    import wtc_pkg::*;

    result_t               mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   rptr_reg, rptr_next;
    logic [PTR_BITS-1:0]   wptr_reg, wptr_next;
    logic [PTR_BITS-1:0]   wptr_plus1;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [1:0]            wr_cnt;
    logic                  pop;

    assign wr_cnt     = wr_en ? wr_data.count : 2'd0;
    assign pop        = rd_valid && !rd_stall;
    assign wptr_plus1 = wptr_reg + 1'b1;
    assign rd_valid   = (level_reg != '0);
    assign rd_data    = mem[rptr_reg];
    assign level      = level_reg;

    // Pointer and fill updates
    always_comb
    begin
        wptr_next  = wptr_reg + PTR_BITS'(wr_cnt);
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        level_next = level_reg + LEVEL_BITS'(wr_cnt) - LEVEL_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            level_reg <= level_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[wptr_reg] <= wr_data.slot0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[wptr_plus1] <= wr_data.slot1;
        end
    end

endmodule

// ===== hw/rtl/word_tokenizer_with_comments_core.sv =====
// Top level of the word tokenizer: input register, tokenizer step, result queue.
//
// Usage:
//   Source channel (src_valid/src_stall) carries one request per byte:
//   in_byte, or end_of_input. A byte of 0 also ends the input.
//   Result channel (res_valid/res_stall) carries kind, word_char,
//   line_number, column_number and last_of_run; each request yields
//   zero, one or two results, last_of_run marks the final one.
// Path: the first result of a request reaches res_valid through the
//   input register, then the result queue.
// Throughput: one request per cycle while the queue has room; a request
//   that yields two results hands them out one after the other. The four-entry
//   result queue and the one-result output port set the sustained rate.
// Stall: when res_stall holds, the queue fills; once fewer than two
//   entries are free the held request waits and src_stall rises.
// Reset: rst_n clears the queue, the input register and the tokenizer
//   state (between words, quote and comment off, line 1, column 1).
`timescale 1ns / 1ps

module word_tokenizer_with_comments_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               src_valid,
    output logic                               src_stall,
    input  logic [7:0]                         in_byte,
    input  logic                               end_of_input,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [1:0]                         kind,
    output logic [7:0]                         word_char,
    output logic [wtc_pkg::LINE_BITS-1:0]      line_number,
    output logic [wtc_pkg::COLUMN_BITS-1:0]    column_number,
    output logic                               last_of_run
);
    import wtc_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  eoi_reg;
    logic                  advance;
    logic [LEVEL_BITS-1:0] level;
    step_out_t             step_out;
    result_t               head;

    // Hold the request until the queue has room for its results
    assign advance   = in_valid_reg && (level <= LEVEL_BITS'(QUEUE_DEPTH - 2));
    assign src_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_byte_reg <= in_byte;
            eoi_reg     <= end_of_input;
        end
    end

    wtc_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_byte      (in_byte_reg),
        .end_of_input (eoi_reg),
        .step_out     (step_out)
    );

    wtc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (advance),
        .wr_data  (step_out),
        .rd_stall (res_stall),
        .rd_valid (res_valid),
        .rd_data  (head),
        .level    (level)
    );

    assign kind          = head.kind;
    assign word_char     = head.word_char;
    assign line_number   = head.line_number;
    assign column_number = head.column_number;
    assign last_of_run   = head.last_of_run;

    // Queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LEVEL_BITS'(QUEUE_DEPTH))
        else $error("result queue over capacity");

    // An end-of-input request always yields at least the input-end result
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eoi_reg) |-> (step_out.count != 2'd0))
        else $error("end of input produced no result");

    // Results leave only through a completed transfer
    a_valid_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_valid) |-> $past(!res_stall))
        else $error("result withdrawn without transfer");

    // Source is only held back while a request waits in the input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (in_valid_reg && level > LEVEL_BITS'(QUEUE_DEPTH - 2)))
        else $error("source stalled without a waiting request");

endmodule
